@@ hdl/plcl_pkg.sv @@
// Package for the piecewise linear curve lookup block.
// Holds table sizes, field widths, status and command codes and the
// control/status structs shared by the controller and the datapath.
`default_nettype none

package plcl_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 16;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int DIV_STEPS  = COORD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic signed [COORD_W-1:0] FAIL_VALUE     = 16'shFF00;
    localparam logic signed [COORD_W-1:0] DOMAIN_MIN_RST = 16'sh8000;
    localparam logic signed [COORD_W-1:0] DOMAIN_MAX_RST = 16'sh7FFF;

    typedef enum logic [0:0] {
        CMD_APPEND = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOSEG = 2'd2,
        ST_UNSUP = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_LINEAR = 2'd0,
        KIND_COSINE = 2'd1,
        KIND_EXP    = 2'd2,
        KIND_LOG    = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        REG_DOMAIN_MIN = 1'b0,
        REG_DOMAIN_MAX = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic    load_item;
        logic    load_raw;
        logic    append;
        logic    clr_idx;
        logic    advance;
        logic    capture_seg;
        logic    mul;
        logic    div_start;
        logic    finish;
        logic    set_result;
        logic    result_from_point;
        t_status result_status;
        logic    push;
    } t_ctrl_cmd;

    typedef struct packed {
        logic full;
        logic at_end;
        logic bracket;
        logic exact;
        logic prev_linear;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/plcl_if.sv @@
// Channel interfaces of the curve lookup block: request, result and
// configuration write channels, each with valid/ready. Uses plcl_pkg.
`default_nettype none

interface plcl_in_if;
    logic                                 valid;
    logic                                 ready;
    plcl_pkg::t_cmd                       command;
    logic signed [plcl_pkg::COORD_W-1:0]  coord_x;
    logic signed [plcl_pkg::COORD_W-1:0]  coord_y;
    plcl_pkg::t_kind                      curve_kind;

    modport source (output valid, command, coord_x, coord_y, curve_kind, input ready);
    modport sink   (input valid, command, coord_x, coord_y, curve_kind, output ready);
endinterface

interface plcl_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [plcl_pkg::COORD_W-1:0]  value;
    plcl_pkg::t_status                    status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

interface plcl_cfg_if;
    logic                                 valid;
    logic                                 ready;
    plcl_pkg::t_reg_idx                   index;
    logic [plcl_pkg::COORD_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/piecewise_linear_curve_lookup.sv @@
// Piecewise linear curve lookup over up to MAX_POINTS appended breakpoints.
// An append request passes through the append state to the result state.
// A query scans the stored breakpoints, one per cycle, and ends on an exact
// match, on an unsupported segment or at the end of the table; an
// interpolated result goes on through the segment setup, the multiply and
// the restoring divider. One request is in work at a time; its result waits
// in an output register so the next request is taken as soon as the result
// is handed off to that register.
// Depends on plcl_pkg, the channel interfaces, plcl_ctrl and plcl_datapath.
`default_nettype none

module piecewise_linear_curve_lookup (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plcl_in_if.sink    i_req,
    plcl_out_if.source o_rsp,
    plcl_cfg_if.sink   i_cfg
);

    plcl_pkg::t_ctrl_cmd ctrl_cmd;
    plcl_pkg::t_dp_stat  dp_stat;
    logic                in_ready;
    logic                in_fire;

    assign i_req.ready = in_ready;
    assign in_fire     = i_req.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    plcl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_fire    (in_fire),
        .i_in_command (i_req.command),
        .o_in_ready   (in_ready),
        .i_stat       (dp_stat),
        .o_cmd        (ctrl_cmd)
    );

    plcl_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctrl_cmd),
        .o_stat       (dp_stat),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_coord_x    (i_req.coord_x),
        .i_coord_y    (i_req.coord_y),
        .i_curve_kind (i_req.curve_kind),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_out_value  (o_rsp.value),
        .o_out_status (o_rsp.status)
    );

endmodule

`default_nettype wire

@@ hdl/plcl_div.sv @@
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on plcl_pkg for widths.
`default_nettype none

module plcl_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [plcl_pkg::PROD_W-1:0]    i_dividend,
    input  wire logic [plcl_pkg::COORD_W-1:0]   i_divisor,
    output logic                                o_done,
    output logic [plcl_pkg::COORD_W-1:0]        o_quotient
);

    localparam int W = plcl_pkg::COORD_W;

    logic                              r_busy;
    logic                              r_done;
    logic [plcl_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [W-1:0]                      r_rem;
    logic [W-1:0]                      r_low;
    logic [W-1:0]                      r_div;

    logic [W:0]                        trial;
    logic                              fits;

    // The caller guarantees the quotient fits in W bits, so the upper half
    // of the dividend is already below the divisor and only W steps remain.
    always_comb begin
        trial = {r_rem, r_low[W-1]};
        fits  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= plcl_pkg::DIV_CNT_W'(plcl_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - plcl_pkg::DIV_CNT_W'(1);
                if (r_cnt == plcl_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[plcl_pkg::PROD_W-1:W];
            r_low <= i_dividend[W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? W'(trial - {1'b0, r_div}) : trial[W-1:0];
            r_low <= {r_low[W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a finished run");

endmodule

`default_nettype wire

@@ hdl/plcl_datapath.sv @@
// Datapath of the curve lookup: breakpoint store, domain registers, scan
// compare, segment multiply, divider and result/output registers.
// Depends on plcl_pkg and plcl_div.
`default_nettype none

module plcl_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire plcl_pkg::t_ctrl_cmd                   i_cmd,
    output plcl_pkg::t_dp_stat                         o_stat,
    input  wire logic                                  i_cfg_we,
    input  wire plcl_pkg::t_reg_idx                    i_cfg_index,
    input  wire logic [plcl_pkg::COORD_W-1:0]          i_cfg_data,
    input  wire logic signed [plcl_pkg::COORD_W-1:0]   i_coord_x,
    input  wire logic signed [plcl_pkg::COORD_W-1:0]   i_coord_y,
    input  wire plcl_pkg::t_kind                       i_curve_kind,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic signed [plcl_pkg::COORD_W-1:0]        o_out_value,
    output plcl_pkg::t_status                          o_out_status
);

    localparam int W = plcl_pkg::COORD_W;

    logic signed [W-1:0]         r_pt_x    [plcl_pkg::MAX_POINTS];
    logic signed [W-1:0]         r_pt_y    [plcl_pkg::MAX_POINTS];
    plcl_pkg::t_kind             r_pt_kind [plcl_pkg::MAX_POINTS];
    logic [plcl_pkg::CNT_W-1:0]  r_count;

    logic signed [W-1:0]         r_dmin;
    logic signed [W-1:0]         r_dmax;

    logic signed [W-1:0]         r_x;
    logic signed [W-1:0]         r_new_y;
    plcl_pkg::t_kind             r_new_kind;

    logic [plcl_pkg::CNT_W-1:0]  r_idx;
    logic signed [W-1:0]         r_prev_x;
    logic signed [W-1:0]         r_prev_y;
    plcl_pkg::t_kind             r_prev_kind;

    logic [W-1:0]                r_dx;
    logic [W-1:0]                r_span;
    logic [W-1:0]                r_dy_mag;
    logic                        r_dy_neg;
    logic signed [W-1:0]         r_y0;
    logic [plcl_pkg::PROD_W-1:0] r_prod;

    logic signed [W-1:0]         r_res_value;
    plcl_pkg::t_status           r_res_status;

    logic                        r_out_valid;
    logic signed [W-1:0]         r_out_value;
    plcl_pkg::t_status           r_out_status;

    logic signed [W-1:0]         x_clamp;
    logic signed [W-1:0]         cur_x;
    logic signed [W-1:0]         cur_y;
    plcl_pkg::t_kind             cur_kind;
    logic                        full;
    logic                        at_end;
    logic [W:0]                  d_dx;
    logic [W:0]                  d_span;
    logic [W:0]                  d_dy;
    logic [W:0]                  d_dy_abs;
    logic                        div_done;
    logic [W-1:0]                div_q;
    logic [W:0]                  interp;
    logic                        out_free;

    // Max test first, then min test, so a crossed domain yields domain_min.
    always_comb begin
        x_clamp = i_coord_x;
        if (x_clamp > r_dmax) x_clamp = r_dmax;
        if (x_clamp < r_dmin) x_clamp = r_dmin;
    end

    always_comb begin
        cur_x    = r_pt_x[r_idx[plcl_pkg::IDX_W-1:0]];
        cur_y    = r_pt_y[r_idx[plcl_pkg::IDX_W-1:0]];
        cur_kind = r_pt_kind[r_idx[plcl_pkg::IDX_W-1:0]];
        full     = (r_count == plcl_pkg::CNT_W'(plcl_pkg::MAX_POINTS));
        at_end   = (r_idx >= r_count);
        d_dx     = {r_x[W-1], r_x} - {r_prev_x[W-1], r_prev_x};
        d_span   = {cur_x[W-1], cur_x} - {r_prev_x[W-1], r_prev_x};
        d_dy     = {cur_y[W-1], cur_y} - {r_prev_y[W-1], r_prev_y};
        d_dy_abs = d_dy[W] ? (W+1)'(-d_dy) : d_dy;
        interp   = r_dy_neg ? ({r_y0[W-1], r_y0} - {1'b0, div_q})
                            : ({r_y0[W-1], r_y0} + {1'b0, div_q});
        out_free = !r_out_valid || i_out_ready;
    end

    // The bracket at the previous index is tested before the exact match at
    // the current one, which keeps the scan order of one index at a time.
    always_comb begin
        o_stat.full        = full;
        o_stat.at_end      = at_end;
        o_stat.bracket     = !at_end && (r_idx != '0) && (r_prev_x < r_x) && (cur_x > r_x);
        o_stat.exact       = !at_end && (cur_x == r_x);
        o_stat.prev_linear = (r_prev_kind == plcl_pkg::KIND_LINEAR);
        o_stat.div_done    = div_done;
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_pt_x[r_count[plcl_pkg::IDX_W-1:0]]    <= r_x;
            r_pt_y[r_count[plcl_pkg::IDX_W-1:0]]    <= r_new_y;
            r_pt_kind[r_count[plcl_pkg::IDX_W-1:0]] <= r_new_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dmin      <= plcl_pkg::DOMAIN_MIN_RST;
            r_dmax      <= plcl_pkg::DOMAIN_MAX_RST;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.append && !full) begin
                r_count <= r_count + plcl_pkg::CNT_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    plcl_pkg::REG_DOMAIN_MIN: r_dmin <= i_cfg_data;
                    plcl_pkg::REG_DOMAIN_MAX: r_dmax <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.advance) begin
                r_idx <= r_idx + plcl_pkg::CNT_W'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            // Appends store the raw x; only queries are clamped.
            r_x        <= i_cmd.load_raw ? i_coord_x : x_clamp;
            r_new_y    <= i_coord_y;
            r_new_kind <= i_curve_kind;
        end
        if (i_cmd.advance) begin
            r_prev_x    <= cur_x;
            r_prev_y    <= cur_y;
            r_prev_kind <= cur_kind;
        end
        if (i_cmd.capture_seg) begin
            r_dx     <= d_dx[W-1:0];
            r_span   <= d_span[W-1:0];
            r_dy_mag <= d_dy_abs[W-1:0];
            r_dy_neg <= d_dy[W];
            r_y0     <= r_prev_y;
        end
        if (i_cmd.mul) begin
            r_prod <= r_dx * r_dy_mag;
        end
        if (i_cmd.set_result) begin
            r_res_value  <= i_cmd.result_from_point ? cur_y : plcl_pkg::FAIL_VALUE;
            r_res_status <= i_cmd.result_status;
        end else if (i_cmd.finish) begin
            r_res_value  <= interp[W-1:0];
            r_res_status <= plcl_pkg::ST_OK;
        end
        if (i_cmd.push) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    plcl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plcl_pkg::CNT_W'(plcl_pkg::MAX_POINTS))
        else $error("point count beyond table size");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.append && full) |=> $stable(r_count))
        else $error("append to a full table changed the count");

endmodule

`default_nettype wire

@@ hdl/plcl_ctrl.sv @@
// Controller of the curve lookup: sequences append, scan, multiply, divide
// and result hand-off. Depends on plcl_pkg for the command/status structs.
`default_nettype none

module plcl_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_fire,
    input  wire plcl_pkg::t_cmd       i_in_command,
    output logic                      o_in_ready,
    input  wire plcl_pkg::t_dp_stat   i_stat,
    output plcl_pkg::t_ctrl_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.result_status = plcl_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.load_raw  = (i_in_command == plcl_pkg::CMD_APPEND);
                    o_cmd.clr_idx   = 1'b1;
                    n_state = (i_in_command == plcl_pkg::CMD_APPEND) ? S_APPEND : S_SCAN;
                end
            end
            S_APPEND: begin
                o_cmd.append        = 1'b1;
                o_cmd.set_result    = 1'b1;
                o_cmd.result_status = i_stat.full ? plcl_pkg::ST_FULL : plcl_pkg::ST_OK;
                n_state = S_RESP;
            end
            S_SCAN: begin
                if (i_stat.at_end) begin
                    o_cmd.set_result    = 1'b1;
                    o_cmd.result_status = plcl_pkg::ST_NOSEG;
                    n_state = S_RESP;
                end else if (i_stat.bracket) begin
                    if (i_stat.prev_linear) begin
                        o_cmd.capture_seg = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        o_cmd.set_result    = 1'b1;
                        o_cmd.result_status = plcl_pkg::ST_UNSUP;
                        n_state = S_RESP;
                    end
                end else if (i_stat.exact) begin
                    o_cmd.set_result        = 1'b1;
                    o_cmd.result_from_point = 1'b1;
                    n_state = S_RESP;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("request taken outside idle");

    a_div_then_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_GO) |=> (r_state == S_DIV))
        else $error("divider run not followed");

endmodule

`default_nettype wire

@@ dv/piecewise_linear_curve_lookup_tb.sv @@
// Testbench for piecewise_linear_curve_lookup: directed rows, then random phases over several
// clamp domains, with each result checked against its typed row or a local breakpoint table predictor.
// Depends on plcl_pkg, the channel interfaces in plcl_if.sv and the block itself.
module piecewise_linear_curve_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 212;

    typedef struct packed {
        logic signed [plcl_pkg::COORD_W-1:0] value;
        plcl_pkg::t_status                   status;
    } t_lookup;

    typedef struct packed {
        plcl_pkg::t_cmd                      cmd;
        logic signed [plcl_pkg::COORD_W-1:0] x;
        logic signed [plcl_pkg::COORD_W-1:0] y;
        plcl_pkg::t_kind                     kind;
        logic                                typed;
        t_lookup                             result;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    plcl_in_if  req_ch ();
    plcl_out_if rsp_ch ();
    plcl_cfg_if cfg_ch ();

    piecewise_linear_curve_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: the breakpoint table and the clamp domain.
    logic signed [plcl_pkg::COORD_W-1:0] pt_x [plcl_pkg::MAX_POINTS];
    logic signed [plcl_pkg::COORD_W-1:0] pt_y [plcl_pkg::MAX_POINTS];
    plcl_pkg::t_kind                     pt_kind [plcl_pkg::MAX_POINTS];
    int                                  stored;
    logic signed [plcl_pkg::COORD_W-1:0] dom_min;
    logic signed [plcl_pkg::COORD_W-1:0] dom_max;

    t_lookup pending_lookups [$];
    t_row    directed_rows [$];
    int      mismatches;
    int      gap_max;
    int      stall_max;
    int      idle_cycles;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic add_row(input t_row r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Applies one request to the predictor state and returns the result it causes.
    function automatic t_lookup curve_eval(input plcl_pkg::t_cmd cmd,
                                           input logic signed [plcl_pkg::COORD_W-1:0] x_in,
                                           input logic signed [plcl_pkg::COORD_W-1:0] y_in,
                                           input plcl_pkg::t_kind kind_in);
        t_lookup res;
        int      qx;
        longint  x0;
        longint  x1;
        longint  y0;
        longint  y1;
        res.value  = plcl_pkg::FAIL_VALUE;
        res.status = plcl_pkg::ST_NOSEG;
        if (cmd == plcl_pkg::CMD_APPEND) begin
            if (stored >= plcl_pkg::MAX_POINTS) begin
                res.status = plcl_pkg::ST_FULL;
            end else begin
                pt_x[stored]    = x_in;
                pt_y[stored]    = y_in;
                pt_kind[stored] = kind_in;
                stored++;
                res.status = plcl_pkg::ST_OK;
            end
            return res;
        end
        // The max clamp goes first, so an inverted domain leaves x at dom_min.
        qx = int'(x_in);
        if (qx > int'(dom_max)) qx = int'(dom_max);
        if (qx < int'(dom_min)) qx = int'(dom_min);
        for (int i = 0; i < stored; i++) begin
            if (int'(pt_x[i]) == qx) begin
                res.value  = pt_y[i];
                res.status = plcl_pkg::ST_OK;
                return res;
            end
            if (i + 1 < stored && int'(pt_x[i]) < qx && int'(pt_x[i+1]) > qx) begin
                if (pt_kind[i] != plcl_pkg::KIND_LINEAR) begin
                    res.status = plcl_pkg::ST_UNSUP;
                    return res;
                end
                x0 = longint'(pt_x[i]);
                x1 = longint'(pt_x[i+1]);
                y0 = longint'(pt_y[i]);
                y1 = longint'(pt_y[i+1]);
                res.value  = plcl_pkg::COORD_W'(y0 + ((qx - x0) * (y1 - y0)) / (x1 - x0));
                res.status = plcl_pkg::ST_OK;
                return res;
            end
        end
        return res;
    endfunction

    // Entered at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input t_row r);
        int      gap;
        t_lookup exp_res;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= r.cmd;
        req_ch.coord_x    <= r.x;
        req_ch.coord_y    <= r.y;
        req_ch.curve_kind <= r.kind;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        exp_res = curve_eval(r.cmd, r.x, r.y, r.kind);
        pending_lookups.insert(pending_lookups.size(), r.typed ? r.result : exp_res);
        @(negedge i_clk);
    endtask

    task automatic set_domain(input logic signed [plcl_pkg::COORD_W-1:0] lo,
                              input logic signed [plcl_pkg::COORD_W-1:0] hi);
        plcl_pkg::t_reg_idx           idx [2];
        logic [plcl_pkg::COORD_W-1:0] val [2];
        idx[0] = plcl_pkg::REG_DOMAIN_MIN;
        idx[1] = plcl_pkg::REG_DOMAIN_MAX;
        val[0] = lo;
        val[1] = hi;
        for (int k = 0; k < 2; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= val[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            if (idx[k] == plcl_pkg::REG_DOMAIN_MIN) dom_min = val[k];
            else dom_max = val[k];
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_lookups.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Result side: a fresh stall is drawn for every result.
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && i_rst_n)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lookups.size() == 0) begin
                flag_mismatch("result arrived with no request pending");
            end else begin
                want = pending_lookups.pop_front();
                if (rsp_ch.value !== want.value)
                    flag_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_ch.value, want.value));
                if (rsp_ch.status !== want.status)
                    flag_mismatch($sformatf("status %s, expected %s",
                                            rsp_ch.status.name(), want.status.name()));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_row                                r;
        int                                  roll;
        int                                  seg;
        int                                  lo;
        int                                  hi;
        int                                  last_x;
        logic signed [plcl_pkg::COORD_W-1:0] d_lo;
        logic signed [plcl_pkg::COORD_W-1:0] d_hi;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = plcl_pkg::CMD_APPEND;
        req_ch.coord_x    = '0;
        req_ch.coord_y    = '0;
        req_ch.curve_kind = plcl_pkg::KIND_LINEAR;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = plcl_pkg::REG_DOMAIN_MIN;
        cfg_ch.data       = '0;
        stored            = 0;
        dom_min           = plcl_pkg::DOMAIN_MIN_RST;
        dom_max           = plcl_pkg::DOMAIN_MAX_RST;
        mismatches        = 0;
        idle_cycles       = 0;
        gap_max           = 18;
        stall_max         = 18;

        // cmd, x, y, kind, typed, {value, status}
        add_row('{plcl_pkg::CMD_QUERY,  16'sd0, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_NOSEG}});
        add_row('{plcl_pkg::CMD_APPEND, -16'sd32768, -16'sd32768, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  -16'sd32768, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{-16'sd32768, plcl_pkg::ST_OK}});
        // A lone last point is only ever an exact match.
        add_row('{plcl_pkg::CMD_QUERY,  16'sd5, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_NOSEG}});
        add_row('{plcl_pkg::CMD_APPEND, -16'sd256, 16'sd32767, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  -16'sd1000, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b0,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  -16'sd257, -16'sd1, plcl_pkg::KIND_LOG, 1'b0,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  -16'sd32767, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b0,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  -16'sd256, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{16'sd32767, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_APPEND, 16'sd0, 16'sd0, plcl_pkg::KIND_COSINE, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  -16'sd100, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b0,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_APPEND, 16'sd512, -16'sd512, plcl_pkg::KIND_EXP, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  16'sd100, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_UNSUP}});
        add_row('{plcl_pkg::CMD_APPEND, 16'sd32767, 16'sd32767, plcl_pkg::KIND_LOG, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  16'sd1000, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_UNSUP}});
        add_row('{plcl_pkg::CMD_QUERY,  16'sd32767, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{16'sd32767, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  16'sd512, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{-16'sd512, plcl_pkg::ST_OK}});
        // Out-of-order point: the scan still takes the first hit by index.
        add_row('{plcl_pkg::CMD_APPEND, 16'sd300, -16'sd32768, plcl_pkg::KIND_LINEAR, 1'b1,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  16'sd300, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b0,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});
        add_row('{plcl_pkg::CMD_QUERY,  16'sd32766, 16'sd0, plcl_pkg::KIND_LINEAR, 1'b0,
                  '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK}});

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) send_request(directed_rows[n]);
        req_ch.valid <= 1'b0;
        last_x = 300;

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin d_lo = -16'sd32768; d_hi = 16'sd32767;  end
                1: begin d_lo = 16'sd32767;  d_hi = -16'sd32768; end
                2: begin
                    d_lo = plcl_pkg::COORD_W'($urandom);
                    d_hi = d_lo;
                end
                3: begin d_lo = -16'sd1024;  d_hi = 16'sd4096;    end
                4: begin
                    d_lo = plcl_pkg::COORD_W'($urandom);
                    d_hi = plcl_pkg::COORD_W'($urandom);
                end
                default: begin
                    d_lo = plcl_pkg::COORD_W'(-32768 + int'($urandom_range(0, 16384)));
                    d_hi = plcl_pkg::COORD_W'(32767 - int'($urandom_range(0, 16384)));
                end
            endcase
            set_domain(d_lo, d_hi);
            gap_max   = (phase % 3 == 2) ? 0 : 18;
            stall_max = (phase % 3 == 2) ? 0 : 18;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r.typed      = 1'b0;
                r.result     = '{plcl_pkg::FAIL_VALUE, plcl_pkg::ST_OK};
                r.y          = plcl_pkg::COORD_W'($urandom);
                r.kind       = plcl_pkg::t_kind'($urandom_range(0, 3));
                roll         = $urandom_range(0, 99);
                if (roll < 12) begin
                    // Mostly rising linear breakpoints so that later queries interpolate.
                    r.cmd = plcl_pkg::CMD_APPEND;
                    if ($urandom_range(0, 9) < 7 && last_x < 32767 - 3000) begin
                        r.x = plcl_pkg::COORD_W'(last_x + int'($urandom_range(1, 3000)));
                    end else begin
                        r.x = plcl_pkg::COORD_W'($urandom);
                    end
                    if ($urandom_range(0, 9) < 7) r.kind = plcl_pkg::KIND_LINEAR;
                    if ($urandom_range(0, 9) == 0) r.y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    last_x = int'(r.x);
                end else begin
                    r.cmd = plcl_pkg::CMD_QUERY;
                    roll  = $urandom_range(0, 99);
                    r.x   = plcl_pkg::COORD_W'($urandom);
                    if (roll < 45 && stored >= 2) begin
                        seg = $urandom_range(0, stored - 2);
                        lo  = int'(pt_x[seg]);
                        hi  = int'(pt_x[seg+1]);
                        if (lo + 1 < hi)
                            r.x = plcl_pkg::COORD_W'(lo + 1 + int'($urandom_range(0, hi - lo - 2)));
                    end else if (roll < 65 && stored >= 1) begin
                        r.x = pt_x[$urandom_range(0, stored - 1)];
                    end else if (roll < 80) begin
                        case ($urandom_range(0, 5))
                            0: r.x = dom_min;
                            1: r.x = dom_max;
                            2: r.x = dom_min - 16'sd1;
                            3: r.x = dom_max + 16'sd1;
                            4: r.x = -16'sd32768;
                            default: r.x = 16'sd32767;
                        endcase
                    end
                end
                send_request(r);
            end
            req_ch.valid <= 1'b0;
        end

        drain_results();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
